// ===== src/heartbeat_liveness_table_top_assert.svh =====
// Assertion macros used by the checker file of the liveness table.
`ifndef HEARTBEAT_LIVENESS_TABLE_TOP_ASSERT_SVH
`define HEARTBEAT_LIVENESS_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define HLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("liveness table implication violated");

// Next-cycle implication, ignored while reset is held.
`define HLT_ASSERT_NXT_DIS(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("liveness table next-cycle check violated");

// Next-cycle implication that is also checked across reset.
`define HLT_ASSERT_NXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("liveness table reset check violated");

`endif

// ===== src/hlt_pkg.sv =====
package hlt_pkg;

  // Item operation codes carried in tuser.
  typedef enum logic [1:0] {
    OP_HEARTBEAT = 2'd0,
    OP_CHECK     = 2'd1,
    OP_QUERY     = 2'd2
  } op_t;

  // Liveness state of one server entry.
  typedef enum logic [1:0] {
    LIVE_ONLINE   = 2'd0,
    LIVE_UNSTABLE = 2'd1,
    LIVE_OFFLINE  = 2'd2
  } live_t;

  // Topology read/write status codes; any other code counts as readwrite.
  localparam logic [1:0] RW_PENDING = 2'd1;
  localparam logic [1:0] RW_RETIRED = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE = 1'b1;

  // One stored table entry.
  typedef struct packed {
    live_t       live;
    logic [31:0] last_hb;
  } entry_t;

  // One input item.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  server_id;
    logic [31:0] time_ms;
    logic        found;
    logic [1:0]  rw_status;
    logic        has_copysets;
    logic        update_ok;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        entry_present;
    logic        state_changed;
    live_t       live_state;
    logic        retire_request;
    logic        entry_removed;
    logic [31:0] last_seen_ms;
  } result_t;

  // Table update produced for one item.
  typedef struct packed {
    logic   mem_we;
    logic   valid_set;
    logic   valid_clr;
    entry_t entry;
  } update_t;

endpackage

// ===== src/heartbeat_liveness_table_top.sv =====
// Heartbeat liveness table: an accepted item is held in the item stage register,
// and its result then in the result register, which drives the result channel.
// Throughput is one item per cycle unless the result channel stalls: the
// entry read-modify-write is forwarded between back-to-back items on the
// same server id. Reset (rst_n low, synchronous) clears all entry valid bits,
// both timeouts and the pipeline; stored time stamps and states need no reset.
module heartbeat_liveness_table_top
  import hlt_pkg::*;
#(
  parameter int ENTRIES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input channel.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // tdata, from bit 0: server_id[7:0], time_ms[31:0], found_in_topology,
  // rw_status[1:0], has_copysets, retire_update_ok, zero pad[2:0].
  input  logic [47:0]          in_tdata,
  // tuser, from bit 0: opcode[1:0].
  input  logic [1:0]           in_tuser,
  // Result channel.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // tdata, from bit 0: entry_present, state_changed, live_state[1:0],
  // retire_request, entry_removed, last_seen_ms[31:0], zero pad[1:0].
  output logic [39:0]          out_tdata,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  // Server ids are 8 bits wide, so at most 256 entries are reachable.
  localparam int DEPTH = (ENTRIES < 256) ? ENTRIES : 256;
  localparam int IDX_W = $clog2(DEPTH);

  item_t             in_item;
  item_t             s1_item_r;
  logic              s1_valid_r;
  logic              s1_adv;
  logic              in_accept;
  logic [IDX_W-1:0]  s1_idx;
  logic              s1_in_range;
  logic [DEPTH-1:0]  valid_r;
  logic [31:0]       miss_timeout_r;
  logic [31:0]       offline_timeout_r;
  entry_t            rd_entry;
  result_t           res;
  update_t           upd;
  result_t           out_res_r;
  logic              out_valid_r;

  // Unpack the input transfer.
  assign in_item.opcode       = in_tuser;
  assign in_item.server_id    = in_tdata[7:0];
  assign in_item.time_ms      = in_tdata[39:8];
  assign in_item.found        = in_tdata[40];
  assign in_item.rw_status    = in_tdata[42:41];
  assign in_item.has_copysets = in_tdata[43];
  assign in_item.update_ok    = in_tdata[44];

  // Handshakes: the item stage moves on whenever the result register is free.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign s1_idx      = IDX_W'(s1_item_r.server_id);
  assign s1_in_range = (32'(s1_item_r.server_id) < 32'(ENTRIES));

  // Entry storage with same-address forwarding.
  hlt_entry_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (s1_adv && upd.mem_we),
    .wr_addr (s1_idx),
    .wr_data (upd.entry),
    .rd_en   (in_accept),
    .rd_addr (IDX_W'(in_item.server_id)),
    .rd_data (rd_entry)
  );

  // Classification, retirement and result formation.
  hlt_decide u_decide (
    .item            (s1_item_r),
    .in_range        (s1_in_range),
    .valid           (valid_r[s1_idx]),
    .ent             (rd_entry),
    .miss_timeout    (miss_timeout_r),
    .offline_timeout (offline_timeout_r),
    .res             (res),
    .upd             (upd)
  );

  // Control state, entry valid bits and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      valid_r           <= '0;
      miss_timeout_r    <= '0;
      offline_timeout_r <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_adv && upd.valid_set) begin
        valid_r[s1_idx] <= 1'b1;
      end else if (s1_adv && upd.valid_clr) begin
        valid_r[s1_idx] <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MISS:    miss_timeout_r    <= cfg_data;
          CFG_OFFLINE: offline_timeout_r <= cfg_data;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  // Pack the result transfer.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       out_res_r.last_seen_ms,
                       out_res_r.entry_removed,
                       out_res_r.retire_request,
                       out_res_r.live_state,
                       out_res_r.state_changed,
                       out_res_r.entry_present};

endmodule

// ===== src/hlt_entry_mem.sv =====
module hlt_entry_mem
  import hlt_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];
  entry_t q_r;
  entry_t byp_r;
  logic   hit_r;

  // One write and one registered read per cycle. A read that meets a write
  // to the same address in the same cycle keeps the written data instead.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r   <= mem[rd_addr];
      hit_r <= wr_en && (wr_addr == rd_addr);
      byp_r <= wr_data;
    end
  end

  assign rd_data = hit_r ? byp_r : q_r;

endmodule

// ===== src/hlt_decide.sv =====
module hlt_decide
  import hlt_pkg::*;
(
  input  item_t       item,
  input  logic        in_range,
  input  logic        valid,
  input  entry_t      ent,
  input  logic [31:0] miss_timeout,
  input  logic [31:0] offline_timeout,
  output result_t     res,
  output update_t     upd
);

  logic [31:0] elapsed;
  live_t       ns;
  logic        present;
  logic        retire;

  // Wrapping elapsed time and its classification against the two timeouts.
  always_comb begin
    elapsed = item.time_ms - ent.last_hb;
    if (elapsed < miss_timeout) begin
      ns = LIVE_ONLINE;
    end else if (elapsed < offline_timeout) begin
      ns = LIVE_UNSTABLE;
    end else begin
      ns = LIVE_OFFLINE;
    end
  end

  assign present = in_range && valid;

  // Result fields and the table update for one item.
  always_comb begin
    res       = '0;
    upd       = '0;
    upd.entry = ent;
    retire    = 1'b0;
    unique case (item.opcode)
      OP_HEARTBEAT: begin
        if (in_range) begin
          res.entry_present = present;
          res.live_state    = present ? ent.live : LIVE_UNSTABLE;
          res.last_seen_ms  = item.time_ms;
          upd.mem_we        = 1'b1;
          upd.valid_set     = 1'b1;
          upd.entry.live    = present ? ent.live : LIVE_UNSTABLE;
          upd.entry.last_hb = item.time_ms;
        end
      end
      OP_CHECK: begin
        if (present) begin
          // Online servers and servers unknown to topology never retire.
          if (ns != LIVE_ONLINE && item.found) begin
            if (item.rw_status == RW_RETIRED) begin
              retire = 1'b1;
            end else if ((ns == LIVE_OFFLINE || item.rw_status == RW_PENDING) &&
                         !item.has_copysets) begin
              res.retire_request = 1'b1;
              retire             = item.update_ok;
            end
          end
          res.entry_present = 1'b1;
          res.state_changed = (ns != ent.live);
          res.live_state    = ns;
          res.entry_removed = retire;
          res.last_seen_ms  = ent.last_hb;
          upd.mem_we        = 1'b1;
          upd.valid_clr     = retire;
          upd.entry.live    = ns;
        end
      end
      OP_QUERY: begin
        if (present) begin
          res.entry_present = 1'b1;
          res.live_state    = ent.live;
          res.last_seen_ms  = ent.last_hb;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

// ===== src/hlt_checker.sv =====
`include "heartbeat_liveness_table_top_assert.svh"

module hlt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // A stalled result transfer keeps its data.
  `HLT_ASSERT_NXT_DIS(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Reset empties the result register.
  `HLT_ASSERT_NXT(a_out_reset, clk, !rst_n, !out_tvalid)

  // A removed entry was present and was not online.
  `HLT_ASSERT_IMP(a_removed_present, clk, rst_n, out_tvalid && out_tdata[5], out_tdata[0] && (out_tdata[3:2] != 2'b00))

  // A state change or a retire request is only reported for a present entry.
  `HLT_ASSERT_IMP(a_change_present, clk, rst_n, out_tvalid && (out_tdata[1] || out_tdata[4]), out_tdata[0])

endmodule

bind heartbeat_liveness_table_top hlt_checker u_hlt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/tb_heartbeat_liveness_table_top.sv =====
`timescale 1ns / 1ps

module tb_heartbeat_liveness_table_top;
  import hlt_pkg::*;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [1:0] RW_READWRITE = 2'd0;
  localparam logic [1:0] RW_UNKNOWN   = 2'd3;

  // One row of the directed table; a pinned row carries its result typed in.
  typedef struct {
    item_t   it;
    bit      pin;
    result_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [47:0]          in_tdata = '0;
  logic [1:0]           in_tuser = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MISS;
  logic [31:0]          cfg_data = '0;

  // Typed-in expectation that travels with the item being offered.
  bit      pin_use = 1'b0;
  result_t pin_want = '0;

  // Shadow of the table and of the timeouts.
  bit          table_valid [256];
  logic [31:0] table_hb [256];
  live_t       table_live [256];
  logic [31:0] miss_ms = '0;
  logic [31:0] offline_ms = '0;

  // Expected results in transfer order.
  result_t     pending_results [$];
  int          n_sent = 0;
  int          n_got = 0;
  int          mismatches = 0;

  // Stimulus bookkeeping: last heartbeat time sent per id.
  bit [31:0]   sent_hb [256];
  int          id_base = 0;

  dir_row_t    dir_rows [$];

  heartbeat_liveness_table_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Classifies one item against the shadow table and updates the shadow.
  function automatic result_t predict_liveness(item_t it);
    result_t     r;
    bit          present;
    logic [31:0] elapsed;
    live_t       ns;
    bit          retire;
    r = '0;
    present = table_valid[it.server_id];
    retire = 1'b0;
    case (it.opcode)
      OP_HEARTBEAT: begin
        if (!present) begin
          table_valid[it.server_id] = 1'b1;
          table_live[it.server_id] = LIVE_UNSTABLE;
        end
        table_hb[it.server_id] = it.time_ms;
        r.live_state = table_live[it.server_id];
        r.last_seen_ms = it.time_ms;
      end
      OP_CHECK: begin
        if (present) begin
          elapsed = it.time_ms - table_hb[it.server_id];
          if (elapsed < miss_ms) ns = LIVE_ONLINE;
          else if (elapsed < offline_ms) ns = LIVE_UNSTABLE;
          else ns = LIVE_OFFLINE;
          if (ns != table_live[it.server_id]) begin
            r.state_changed = 1'b1;
            table_live[it.server_id] = ns;
          end
          // Only a non-online server that topology knows can be retired.
          if (ns != LIVE_ONLINE && it.found) begin
            if (it.rw_status == RW_RETIRED) begin
              retire = 1'b1;
            end else if ((ns == LIVE_OFFLINE || it.rw_status == RW_PENDING) &&
                         !it.has_copysets) begin
              r.retire_request = 1'b1;
              retire = it.update_ok;
            end
          end
          r.live_state = ns;
          r.last_seen_ms = table_hb[it.server_id];
          if (retire) begin
            r.entry_removed = 1'b1;
            table_valid[it.server_id] = 1'b0;
          end
        end
      end
      OP_QUERY: begin
        if (present) begin
          r.live_state = table_live[it.server_id];
          r.last_seen_ms = table_hb[it.server_id];
        end
      end
      default: ;
    endcase
    r.entry_present = present && (it.opcode != OP_UNUSED);
    return r;
  endfunction

  // Predicts every accepted item and checks every accepted result.
  always @(posedge clk) begin
    item_t   it;
    result_t want;
    result_t r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        it.opcode = in_tuser;
        it.server_id = in_tdata[7:0];
        it.time_ms = in_tdata[39:8];
        it.found = in_tdata[40];
        it.rw_status = in_tdata[42:41];
        it.has_copysets = in_tdata[43];
        it.update_ok = in_tdata[44];
        r = predict_liveness(it);
        pending_results.push_back(pin_use ? pin_want : r);
      end
      if (out_tvalid && out_tready) begin
        n_got++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", out_tdata[31:0], '0);
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[0] !== want.entry_present)
            report_mismatch("entry_present", 32'(out_tdata[0]), 32'(want.entry_present));
          if (out_tdata[1] !== want.state_changed)
            report_mismatch("state_changed", 32'(out_tdata[1]), 32'(want.state_changed));
          if (out_tdata[3:2] !== want.live_state)
            report_mismatch("live_state", 32'(out_tdata[3:2]), 32'(want.live_state));
          if (out_tdata[4] !== want.retire_request)
            report_mismatch("retire_request", 32'(out_tdata[4]), 32'(want.retire_request));
          if (out_tdata[5] !== want.entry_removed)
            report_mismatch("entry_removed", 32'(out_tdata[5]), 32'(want.entry_removed));
          if (out_tdata[37:6] !== want.last_seen_ms)
            report_mismatch("last_seen_ms", out_tdata[37:6], want.last_seen_ms);
        end
      end
    end
  end

  // Receiver back-pressure: the pattern is picked anew at random from four modes.
  always @(posedge clk) begin
    int unsigned rx_cycle;
    int unsigned rx_mode;
    rx_cycle++;
    if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((rx_cycle % 8) < 3);
    endcase
  end

  function automatic item_t mk_item(logic [1:0] op, logic [7:0] id, logic [31:0] t,
                                    logic f, logic [1:0] rw, logic cs, logic ok);
    item_t it;
    it.opcode = op;
    it.server_id = id;
    it.time_ms = t;
    it.found = f;
    it.rw_status = rw;
    it.has_copysets = cs;
    it.update_ok = ok;
    return it;
  endfunction

  function automatic result_t mk_result(logic present, logic changed, live_t st,
                                        logic req, logic rem, logic [31:0] seen);
    result_t r;
    r.entry_present = present;
    r.state_changed = changed;
    r.live_state = st;
    r.retire_request = req;
    r.entry_removed = rem;
    r.last_seen_ms = seen;
    return r;
  endfunction

  // Offers one item and waits for its transfer; valid stays high afterwards.
  task automatic send_item(item_t it, bit pin, result_t want);
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, it.update_ok, it.has_copysets, it.rw_status, it.found,
                 it.time_ms, it.server_id};
    in_tuser <= it.opcode;
    pin_use <= pin;
    pin_want <= want;
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  // Sender gap with junk on the data lines.
  task automatic go_idle(int cycles);
    in_tvalid <= 1'b0;
    in_tdata <= 48'({$urandom, $urandom});
    in_tuser <= 2'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the sender until every expected result has come and the pipe is empty.
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (n_got != n_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the channel is left idle after the transfer.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MISS) miss_ms = val;
    else offline_ms = val;
    @(posedge clk);
  endtask

  // Random item, biased toward known ids and times near the timeout edges.
  function automatic item_t gen_item();
    item_t       it;
    int unsigned pick;
    logic [31:0] ofs;
    it = mk_item(OP_QUERY, '0, '0, $urandom_range(0, 9) != 0, 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 4) != 0) it.server_id = 8'(id_base + $urandom_range(0, 7));
    else it.server_id = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 30) it.opcode = OP_HEARTBEAT;
    else if (pick < 75) it.opcode = OP_CHECK;
    else if (pick < 95) it.opcode = OP_QUERY;
    else it.opcode = OP_UNUSED;
    case ($urandom_range(0, 8))
      0: ofs = miss_ms - 1;
      1: ofs = miss_ms;
      2: ofs = offline_ms - 1;
      3: ofs = offline_ms;
      4: ofs = offline_ms + 1;
      5: ofs = 0;
      6: ofs = $urandom;
      default: ofs = $urandom_range(0, 400);
    endcase
    if (it.opcode == OP_HEARTBEAT) begin
      it.time_ms = ($urandom_range(0, 3) == 0) ? $urandom :
                   sent_hb[it.server_id] + $urandom_range(0, 500);
      sent_hb[it.server_id] = it.time_ms;
    end else begin
      it.time_ms = sent_hb[it.server_id] + ofs;
    end
    return it;
  endfunction

  // One random phase in bursts, under the given timeouts.
  task automatic run_phase(logic [31:0] miss, logic [31:0] offl, int count);
    int sent;
    int burst;
    bit no_gaps;
    quiesce();
    write_reg(CFG_MISS, miss);
    write_reg(CFG_OFFLINE, offl);
    id_base = $urandom_range(0, 248);
    no_gaps = ($urandom_range(0, 3) == 0);
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_item(gen_item(), 1'b0, '0);
        sent++;
      end
      if (!no_gaps && $urandom_range(0, 3) != 0) go_idle($urandom_range(1, 6));
    end
  endtask

  // Run limit.
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    // Directed table: absent entries, table extremes, every retirement path,
    // a wrapping elapsed time and back-to-back items on one id.
    dir_rows.push_back('{mk_item(OP_QUERY, 8'd0, 32'd0, 1, RW_READWRITE, 0, 0), 1,
                         mk_result(0, 0, LIVE_ONLINE, 0, 0, 32'd0)});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd255, 32'hFFFF_FFFF, 1, RW_RETIRED, 0, 1), 1,
                         mk_result(0, 0, LIVE_ONLINE, 0, 0, 32'd0)});
    dir_rows.push_back('{mk_item(OP_UNUSED, 8'd7, 32'hFFFF_FFFF, 1, RW_UNKNOWN, 1, 1), 1,
                         mk_result(0, 0, LIVE_ONLINE, 0, 0, 32'd0)});
    dir_rows.push_back('{mk_item(OP_HEARTBEAT, 8'd0, 32'd0, 0, RW_READWRITE, 0, 0), 1,
                         mk_result(0, 0, LIVE_UNSTABLE, 0, 0, 32'd0)});
    dir_rows.push_back('{mk_item(OP_HEARTBEAT, 8'd255, 32'hFFFF_FFFF, 1, RW_UNKNOWN, 1, 1), 1,
                         mk_result(0, 0, LIVE_UNSTABLE, 0, 0, 32'hFFFF_FFFF)});
    dir_rows.push_back('{mk_item(OP_HEARTBEAT, 8'd0, 32'd50, 0, RW_READWRITE, 0, 0), 1,
                         mk_result(1, 0, LIVE_UNSTABLE, 0, 0, 32'd50)});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd0, 32'd60, 1, RW_READWRITE, 0, 0), 0, '0});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd0, 32'd60, 1, RW_READWRITE, 0, 0), 0, '0});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd255, 32'h0000_03E6, 1, RW_PENDING, 0, 0), 0,
                         '0});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd0, 32'd1050, 1, RW_READWRITE, 0, 1), 0, '0});
    dir_rows.push_back('{mk_item(OP_QUERY, 8'd0, 32'd1050, 1, RW_READWRITE, 0, 0), 1,
                         mk_result(0, 0, LIVE_ONLINE, 0, 0, 32'd0)});
    dir_rows.push_back('{mk_item(OP_HEARTBEAT, 8'd10, 32'd500, 1, RW_READWRITE, 0, 0), 0,
                         '0});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd10, 32'd600, 1, RW_RETIRED, 1, 0), 0, '0});
    dir_rows.push_back('{mk_item(OP_HEARTBEAT, 8'd20, 32'd0, 1, RW_READWRITE, 0, 0), 0, '0});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd20, 32'd99, 0, RW_RETIRED, 0, 1), 0, '0});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd20, 32'd2000, 0, RW_PENDING, 0, 1), 0, '0});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd20, 32'd2000, 1, RW_UNKNOWN, 1, 1), 0, '0});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd20, 32'd2000, 1, RW_UNKNOWN, 0, 0), 0, '0});
    dir_rows.push_back('{mk_item(OP_HEARTBEAT, 8'd20, 32'd2000, 1, RW_READWRITE, 0, 0), 0,
                         '0});
    dir_rows.push_back('{mk_item(OP_QUERY, 8'd20, 32'd0, 0, RW_READWRITE, 0, 0), 0, '0});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd20, 32'd2999, 1, RW_PENDING, 1, 1), 0, '0});
    dir_rows.push_back('{mk_item(OP_HEARTBEAT, 8'd30, 32'd5, 1, RW_READWRITE, 0, 0), 0, '0});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd30, 32'd5, 1, RW_READWRITE, 0, 0), 0, '0});
    dir_rows.push_back('{mk_item(OP_CHECK, 8'd30, 32'd5000, 1, RW_RETIRED, 1, 0), 0, '0});
    dir_rows.push_back('{mk_item(OP_HEARTBEAT, 8'd30, 32'd7, 1, RW_READWRITE, 0, 0), 0, '0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, items offered back to back.
    write_reg(CFG_MISS, 32'd100);
    write_reg(CFG_OFFLINE, 32'd1000);
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].pin, dir_rows[i].want);

    // Random part across timeout settings, extremes included.
    run_phase(32'd0, 32'd0, 80);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 80);
    run_phase(32'd0, 32'hFFFF_FFFF, 80);
    run_phase(32'hFFFF_FFFF, 32'd0, 80);
    run_phase(32'd50, 32'd300, 80);
    run_phase(32'd300, 32'd50, 80);
    run_phase($urandom, $urandom, 80);
    run_phase(32'd1000, 32'd5000, 80);

    quiesce();
    repeat (6) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never produced", 32'(pending_results.size()), '0);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/hlt_pkg.sv
src/hlt_entry_mem.sv
src/hlt_decide.sv
src/heartbeat_liveness_table_top.sv
src/hlt_checker.sv
verif/tb_heartbeat_liveness_table_top.sv
